>>> rtl/dhte_pkg.sv
// shared constants and codes for the double hashing table engine
package dhte_pkg;

  localparam int unsigned TableSize = 1021;
  localparam int unsigned StepPrime = 997;
  localparam int unsigned KeyBits   = 31;
  localparam int unsigned SlotBits  = 10;
  localparam int unsigned CountBits = 10;
  localparam int unsigned TagBits   = 2;
  localparam int unsigned EntryBits = TagBits + KeyBits;

  // reciprocal multiply for the two modulo reductions
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipBits  = 31;
  localparam int unsigned ProdBits   = KeyBits + RecipBits;
  localparam int unsigned QuotBits   = ProdBits - RecipShift;
  localparam int unsigned MulBits    = QuotBits + SlotBits;
  localparam int unsigned RemBits    = SlotBits + 1;

  localparam logic [63:0] RecipHomeW = (64'd1 << RecipShift) / 64'(TableSize);
  localparam logic [63:0] RecipStepW = (64'd1 << RecipShift) / 64'(StepPrime);
  localparam logic [RecipBits-1:0] RecipHome = RecipHomeW[RecipBits-1:0];
  localparam logic [RecipBits-1:0] RecipStep = RecipStepW[RecipBits-1:0];

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpSearch = 2'd2;
  localparam logic [1:0] OpHash   = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatNoSlot   = 2'd2;
  localparam logic [1:0] StatInvalid  = 2'd3;

  localparam logic [TagBits-1:0] TagEmpty   = 2'd0;
  localparam logic [TagBits-1:0] TagLive    = 2'd1;
  localparam logic [TagBits-1:0] TagDeleted = 2'd2;

endpackage

>>> rtl/dhte_hash.sv
// three stage home slot and probe step unit using reciprocal multiplication
module dhte_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dhte_pkg::KeyBits-1:0]  key_i,
  output logic                          done_o,
  output logic [dhte_pkg::SlotBits-1:0] home_o,
  output logic [dhte_pkg::SlotBits-1:0] step_o
);

  logic                          v1_q, v2_q, v3_q;
  logic [dhte_pkg::KeyBits-1:0]  key1_q, key2_q;
  logic [dhte_pkg::ProdBits-1:0] prod_h_q, prod_s_q;
  logic [dhte_pkg::MulBits-1:0]  qm_h_q, qm_s_q;
  logic [dhte_pkg::QuotBits-1:0] quot_h, quot_s;
  logic [dhte_pkg::MulBits-1:0]  diff_h, diff_s;
  logic [dhte_pkg::RemBits-1:0]  rem_h, rem_s, red_h, red_s;
  logic [dhte_pkg::SlotBits-1:0] home_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // quotient estimate is exact or one low
  assign quot_h = prod_h_q[dhte_pkg::ProdBits-1:dhte_pkg::RecipShift];
  assign quot_s = prod_s_q[dhte_pkg::ProdBits-1:dhte_pkg::RecipShift];

  assign diff_h = dhte_pkg::MulBits'(key2_q) - qm_h_q;
  assign diff_s = dhte_pkg::MulBits'(key2_q) - qm_s_q;
  assign rem_h  = diff_h[dhte_pkg::RemBits-1:0];
  assign rem_s  = diff_s[dhte_pkg::RemBits-1:0];
  assign red_h  = (rem_h >= dhte_pkg::RemBits'(dhte_pkg::TableSize)) ?
                  rem_h - dhte_pkg::RemBits'(dhte_pkg::TableSize) : rem_h;
  assign red_s  = (rem_s >= dhte_pkg::RemBits'(dhte_pkg::StepPrime)) ?
                  rem_s - dhte_pkg::RemBits'(dhte_pkg::StepPrime) : rem_s;

  always_ff @(posedge clk_i) begin
    key1_q   <= key_i;
    prod_h_q <= dhte_pkg::ProdBits'(key_i) * dhte_pkg::ProdBits'(dhte_pkg::RecipHome);
    prod_s_q <= dhte_pkg::ProdBits'(key_i) * dhte_pkg::ProdBits'(dhte_pkg::RecipStep);
    key2_q   <= key1_q;
    qm_h_q   <= dhte_pkg::MulBits'(quot_h) * dhte_pkg::MulBits'(dhte_pkg::TableSize);
    qm_s_q   <= dhte_pkg::MulBits'(quot_s) * dhte_pkg::MulBits'(dhte_pkg::StepPrime);
    home_q   <= red_h[dhte_pkg::SlotBits-1:0];
    step_q   <= dhte_pkg::SlotBits'(dhte_pkg::StepPrime) - red_s[dhte_pkg::SlotBits-1:0];
  end

  assign done_o = v3_q;
  assign home_o = home_q;
  assign step_o = step_q;

endmodule

>>> rtl/double_hash_table_engine_core.sv
// top level: double hashing open-addressed key table with its slot memory
//
// Input channel in_valid_i/in_ready_o carries one request word: opcode_i
// (insert, remove, search, hash query) and key_value_i. Output channel
// out_valid_o/out_ready_i carries one result word per request: status,
// home slot, probe step, live key count and the empty and full flags.
// A request first passes through the reciprocal hash unit, then walks the
// probe sequence through the slot memory, each probe addressing the memory
// and then evaluating the registered read data. A hash query ends after the
// hash unit, and a zero key skips both the hash unit and the probe walk.
// One request is in flight at a time; the next word is taken once the
// current one has moved into the output register.
// After reset the block sweeps all 1021 slots to empty, one per cycle,
// with in_ready_o low throughout the sweep.
// The output register holds its word while out_ready_i is low; a finished
// request then waits until the register frees before the next is taken.
module double_hash_table_engine_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [dhte_pkg::KeyBits-1:0]   key_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [dhte_pkg::SlotBits-1:0]  home_slot_o,
  output logic [dhte_pkg::SlotBits-1:0]  probe_step_o,
  output logic [dhte_pkg::CountBits-1:0] stored_count_o,
  output logic                           table_empty_o,
  output logic                           table_full_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StHash  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StEval  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [dhte_pkg::SlotBits-1:0]  clr_idx_q, clr_idx_d;
  logic [dhte_pkg::CountBits-1:0] count_q, count_d;
  logic                           out_valid_q, out_valid_d;

  logic [1:0]                     op_q, op_d;
  logic [dhte_pkg::KeyBits-1:0]   key_q, key_d;
  logic [dhte_pkg::SlotBits-1:0]  home_q, home_d;
  logic [dhte_pkg::SlotBits-1:0]  step_q, step_d;
  logic [dhte_pkg::SlotBits-1:0]  slot_q, slot_d;
  logic [dhte_pkg::SlotBits-1:0]  probe_cnt_q, probe_cnt_d;
  logic [1:0]                     status_q, status_d;

  logic [1:0]                     out_status_q;
  logic [dhte_pkg::SlotBits-1:0]  out_home_q, out_step_q;
  logic [dhte_pkg::CountBits-1:0] out_count_q;
  logic                           out_empty_q, out_full_q;

  logic                           hash_start, hash_done;
  logic [dhte_pkg::SlotBits-1:0]  hash_home, hash_step;

  logic [dhte_pkg::EntryBits-1:0] slot_mem [dhte_pkg::TableSize];
  logic [dhte_pkg::EntryBits-1:0] rd_data_q;
  logic                           mem_we;
  logic [dhte_pkg::SlotBits-1:0]  mem_waddr;
  logic [dhte_pkg::EntryBits-1:0] mem_wdata;

  logic [dhte_pkg::TagBits-1:0]   rd_tag;
  logic [dhte_pkg::KeyBits-1:0]   rd_key;
  logic [dhte_pkg::RemBits-1:0]   slot_sum;
  logic [dhte_pkg::SlotBits-1:0]  slot_next;
  logic                           last_probe;
  logic                           out_load;

  dhte_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_value_i),
    .done_o  (hash_done),
    .home_o  (hash_home),
    .step_o  (hash_step)
  );

  assign rd_tag     = rd_data_q[dhte_pkg::EntryBits-1:dhte_pkg::KeyBits];
  assign rd_key     = rd_data_q[dhte_pkg::KeyBits-1:0];
  assign slot_sum   = dhte_pkg::RemBits'(slot_q) + dhte_pkg::RemBits'(step_q);
  assign slot_next  = (slot_sum >= dhte_pkg::RemBits'(dhte_pkg::TableSize)) ?
                      dhte_pkg::SlotBits'(slot_sum - dhte_pkg::RemBits'(dhte_pkg::TableSize)) :
                      slot_sum[dhte_pkg::SlotBits-1:0];
  assign last_probe = (probe_cnt_q == dhte_pkg::SlotBits'(dhte_pkg::TableSize - 1));
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    count_d     = count_q;
    op_d        = op_q;
    key_d       = key_q;
    home_d      = home_q;
    step_d      = step_q;
    slot_d      = slot_q;
    probe_cnt_d = probe_cnt_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_q;
    mem_wdata   = {dhte_pkg::TagLive, key_q};
    hash_start  = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        if (clr_idx_q == dhte_pkg::SlotBits'(dhte_pkg::TableSize - 1)) begin
          state_d = StIdle;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          op_d  = opcode_i;
          key_d = key_value_i;
          if (key_value_i == '0) begin
            home_d   = '0;
            step_d   = '0;
            status_d = dhte_pkg::StatInvalid;
            state_d  = StDone;
          end else begin
            hash_start = 1'b1;
            state_d    = StHash;
          end
        end
      end
      StHash: begin
        if (hash_done) begin
          home_d      = hash_home;
          step_d      = hash_step;
          slot_d      = hash_home;
          probe_cnt_d = '0;
          if (op_q == dhte_pkg::OpHash) begin
            status_d = dhte_pkg::StatOk;
            state_d  = StDone;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StEval;
      end
      StEval: begin
        if (op_q == dhte_pkg::OpInsert) begin
          if (rd_tag != dhte_pkg::TagLive) begin
            mem_we   = 1'b1;
            count_d  = count_q + 1'b1;
            status_d = dhte_pkg::StatOk;
            state_d  = StDone;
          end else if (last_probe) begin
            status_d = dhte_pkg::StatNoSlot;
            state_d  = StDone;
          end else begin
            slot_d      = slot_next;
            probe_cnt_d = probe_cnt_q + 1'b1;
            state_d     = StRead;
          end
        end else begin
          if (rd_tag == dhte_pkg::TagEmpty) begin
            status_d = dhte_pkg::StatNotFound;
            state_d  = StDone;
          end else if (rd_tag == dhte_pkg::TagLive && rd_key == key_q) begin
            // remove leaves a tombstone so later probe chains stay intact
            if (op_q == dhte_pkg::OpRemove) begin
              mem_we    = 1'b1;
              mem_wdata = {dhte_pkg::TagDeleted, key_q};
              count_d   = count_q - 1'b1;
            end
            status_d = dhte_pkg::StatOk;
            state_d  = StDone;
          end else if (last_probe) begin
            status_d = dhte_pkg::StatNotFound;
            state_d  = StDone;
          end else begin
            slot_d      = slot_next;
            probe_cnt_d = probe_cnt_q + 1'b1;
            state_d     = StRead;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_idx_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    home_q      <= home_d;
    step_q      <= step_d;
    slot_q      <= slot_d;
    probe_cnt_q <= probe_cnt_d;
    status_q    <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_home_q   <= home_q;
      out_step_q   <= step_q;
      out_count_q  <= count_q;
      out_empty_q  <= (count_q == '0);
      out_full_q   <= (count_q == dhte_pkg::CountBits'(dhte_pkg::TableSize));
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= slot_mem[slot_q];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign home_slot_o    = out_home_q;
  assign probe_step_o   = out_step_q;
  assign stored_count_o = out_count_q;
  assign table_empty_o  = out_empty_q;
  assign table_full_o   = out_full_q;

endmodule

>>> rtl/dhte_checker.sv
// port level checks for the double hashing table engine, bound to the top level
module dhte_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [1:0]                     status_o,
  input logic [dhte_pkg::SlotBits-1:0]  home_slot_o,
  input logic [dhte_pkg::SlotBits-1:0]  probe_step_o,
  input logic [dhte_pkg::CountBits-1:0] stored_count_o,
  input logic                           table_empty_o,
  input logic                           table_full_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(home_slot_o) && $stable(probe_step_o) && $stable(stored_count_o))
    else $error("result word changed while stalled");

  // flags agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (table_empty_o == (stored_count_o == '0)) &&
      (table_full_o == (stored_count_o == dhte_pkg::CountBits'(dhte_pkg::TableSize))))
    else $error("empty or full flag disagrees with count");

  // zero key gives zero hashes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dhte_pkg::StatInvalid |-> home_slot_o == '0 &&
      probe_step_o == '0)
    else $error("invalid key with nonzero hash fields");

  // hashes in range for valid keys
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dhte_pkg::StatInvalid |->
      home_slot_o < dhte_pkg::SlotBits'(dhte_pkg::TableSize) && probe_step_o != '0 &&
      probe_step_o <= dhte_pkg::SlotBits'(dhte_pkg::StepPrime))
    else $error("hash value out of range");

  // nothing is offered when reset is released, as the clearing sweep begins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("block active right after reset");

endmodule

bind double_hash_table_engine_core dhte_checker u_dhte_checker (.*);
